@@ hw/rtl/c3f_pkg.sv @@
`timescale 1ns / 1ps

package c3f_pkg;

  // Default storage depth of one line store, in padded pixels.
  localparam int MAX_PADDED_WIDTH_DEF = 1024;

  // Field and arithmetic widths.
  localparam int CHAN_W      = 8;
  localparam int PIX_W       = 3 * CHAN_W;
  localparam int COEF_W      = 16;
  localparam int CFG_DATA_W  = 3 * COEF_W;
  localparam int CFG_IDX_W   = 3;
  localparam int IWIDTH_W    = 10;
  localparam int IHEIGHT_W   = 16;
  localparam int TAPS        = 9;
  localparam int LANES       = 3;
  localparam int PROD_W      = CHAN_W + 1 + COEF_W;
  localparam int SUM_W       = PROD_W + 4;
  localparam int FRAC_W      = 8;

  // Largest interior height the row counter supports.
  localparam logic [IHEIGHT_W-1:0] MAX_INTERIOR_HEIGHT = 16'd65533;

  // Color mode codes.
  localparam logic GREY = 1'b0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MID   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 3'd5;

  typedef logic [CHAN_W-1:0]        chan_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Stage enables handed from the pipeline control to each channel lane.
  typedef struct packed {
    logic prod_en;
    logic sum_en;
  } lane_ctl_t;

endpackage

@@ hw/rtl/conv3x3_image_filter_unit.sv @@
`timescale 1ns / 1ps

// 3x3 convolution filter over a streamed, one-pixel-padded image. Pixels of
// the padded frame enter in raster order, one per transfer, and the block
// sustains one pixel per clock when not stalled: two line stores (one read
// and one write port each, MAX_PADDED_WIDTH entries of 24 bits) feed a 3x3
// window, and three channel lanes each run nine Q8.8 multiplies and a sum
// in registered stages. Padding pixels give no result. Each channel result
// is the sum truncated toward zero and clamped to 0..255, and frame_last
// marks the last interior pixel of the frame. The line stores are not
// cleared after reset; they hold valid data once two full padded rows have
// passed. A pixel with frame_start high restarts the frame position.
// Configuration writes are taken on every cycle and must be made while the
// block is idle.
module conv3x3_image_filter_unit #(
  parameter int MAX_PADDED_WIDTH = c3f_pkg::MAX_PADDED_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [c3f_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [c3f_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  c3f_pkg::chan_t                   chan_zero,
  input  c3f_pkg::chan_t                   chan_one,
  input  c3f_pkg::chan_t                   chan_two,
  input  logic                             frame_start,
  output logic                             out_valid,
  input  logic                             out_stall,
  output c3f_pkg::chan_t                   out_zero,
  output c3f_pkg::chan_t                   out_one,
  output c3f_pkg::chan_t                   out_two,
  output logic                             frame_last
);
  import c3f_pkg::*;

  localparam int CW = $clog2(MAX_PADDED_WIDTH);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] coef_row_top;
  logic [CFG_DATA_W-1:0] coef_row_mid;
  logic [CFG_DATA_W-1:0] coef_row_bot;
  logic [IWIDTH_W-1:0]   interior_width;
  logic [IHEIGHT_W-1:0]  interior_height;
  logic                  color_mode;

  // Frame position of the next pixel.
  logic [CW-1:0]        column_count;
  logic [IHEIGHT_W-1:0] row_count;
  logic [CW-1:0]        column_count_next;
  logic [IHEIGHT_W-1:0] row_count_next;
  logic [CW-1:0]        col_cur;
  logic [IHEIGHT_W-1:0] row_cur;
  logic [CW-1:0]        col_last;
  logic [IHEIGHT_W-1:0] row_last;

  // Pipeline stages.
  logic          s1_v, s1_emit, s1_last, s1_fwd;
  logic [PIX_W-1:0] s1_px;
  logic [CW-1:0] s1_col;
  logic          s2_v, s2_last;
  logic          s3_v, s3_last;
  logic          s4_v, s4_last;
  logic          ready1, ready2, ready3, ready4, ready_out;
  logic          accept;

  // Line stores and window.
  logic [PIX_W-1:0] ram_up, ram_mid, up_res, mid_res;
  logic [PIX_W-1:0] last_mid, last_px;
  logic [PIX_W-1:0] window_regs [TAPS];
  logic             store_wr;

  // Lanes.
  coef_t     coefs [TAPS];
  chan_t     lane_taps [LANES][TAPS];
  sum_t      lane_sum [LANES];
  lane_ctl_t lane_ctl;

  // Configuration writes; indexes past the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_row_top    <= '0;
      coef_row_mid    <= CFG_DATA_W'(256);
      coef_row_bot    <= '0;
      interior_width  <= IWIDTH_W'(1022);
      interior_height <= IHEIGHT_W'(1);
      color_mode      <= GREY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COEF_TOP:   coef_row_top    <= cfg_data;
        REG_COEF_MID:   coef_row_mid    <= cfg_data;
        REG_COEF_BOT:   coef_row_bot    <= cfg_data;
        REG_INT_WIDTH:  interior_width  <= cfg_data[IWIDTH_W-1:0];
        REG_INT_HEIGHT: interior_height <= cfg_data[IHEIGHT_W-1:0];
        REG_COLOR_MODE: color_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Last padded column and row after clamping the interior size.
  always_comb begin
    if (interior_width == '0) begin
      col_last = CW'(2);
    end else if (32'(interior_width) > 32'(MAX_PADDED_WIDTH - 2)) begin
      col_last = CW'(MAX_PADDED_WIDTH - 1);
    end else begin
      col_last = CW'(32'(interior_width) + 32'd1);
    end
    if (interior_height == '0) begin
      row_last = IHEIGHT_W'(2);
    end else if (interior_height > MAX_INTERIOR_HEIGHT) begin
      row_last = MAX_INTERIOR_HEIGHT + IHEIGHT_W'(1);
    end else begin
      row_last = interior_height + IHEIGHT_W'(1);
    end
  end

  // Position of the incoming pixel, with frame restart and wrap when the
  // geometry no longer fits the stored position.
  always_comb begin
    col_cur = frame_start ? '0 : column_count;
    row_cur = frame_start ? '0 : row_count;
    if (col_cur > col_last) begin
      col_cur = '0;
      row_cur = row_cur + IHEIGHT_W'(1);
    end
    if (row_cur > row_last) begin
      row_cur = '0;
    end
    if (col_cur == col_last) begin
      column_count_next = '0;
      row_count_next    = (row_cur == row_last) ? '0 : row_cur + IHEIGHT_W'(1);
    end else begin
      column_count_next = col_cur + CW'(1);
      row_count_next    = row_cur;
    end
  end

  // Backpressure chain: a stage moves on when the one after it is empty or
  // moving too.
  assign ready4   = !s4_v || ready_out;
  assign ready3   = !s3_v || ready4;
  assign ready2   = !s2_v || ready3;
  assign ready1   = !s1_v || ready2;
  assign in_stall = !ready1;
  assign accept   = in_valid && ready1;
  assign store_wr = s1_v && ready2;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Stage one: pixel and its position while the line stores are read.
  // The previous pixel writes its column in the same cycle, so a read of
  // that column takes the forwarded values instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (ready1) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px   <= {chan_two, chan_one, chan_zero};
      s1_col  <= col_cur;
      s1_emit <= (row_cur >= IHEIGHT_W'(2)) && (col_cur >= CW'(2));
      s1_last <= (row_cur == row_last) && (col_cur == col_last);
      s1_fwd  <= s1_v && (s1_col == col_cur);
    end
  end

  c3f_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_PADDED_WIDTH)
  ) u_store_upper (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (s1_col),
    .wr_data (mid_res),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (ram_up)
  );

  c3f_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_PADDED_WIDTH)
  ) u_store_middle (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (s1_col),
    .wr_data (s1_px),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (ram_mid)
  );

  assign up_res  = s1_fwd ? last_mid : ram_up;
  assign mid_res = s1_fwd ? last_px  : ram_mid;

  // Window shift as stage one hands its pixel on.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < TAPS; t++) begin
        window_regs[t] <= '0;
      end
    end else if (store_wr) begin
      window_regs[0] <= window_regs[1];
      window_regs[1] <= window_regs[2];
      window_regs[2] <= up_res;
      window_regs[3] <= window_regs[4];
      window_regs[4] <= window_regs[5];
      window_regs[5] <= mid_res;
      window_regs[6] <= window_regs[7];
      window_regs[7] <= window_regs[8];
      window_regs[8] <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      last_mid <= mid_res;
      last_px  <= s1_px;
    end
  end

  // Valid and last flags of the result-bearing stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      if (ready2) begin
        s2_v <= s1_v && s1_emit;
      end
      if (ready3) begin
        s3_v <= s2_v;
      end
      if (ready4) begin
        s4_v <= s3_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      s2_last <= s1_last;
    end
    if (ready3) begin
      s3_last <= s2_last;
    end
    if (ready4) begin
      s4_last <= s3_last;
    end
  end

  // Kernel taps in window order: left column in the low half-word.
  always_comb begin
    for (int q = 0; q < 3; q++) begin
      coefs[q]     = coef_t'(coef_row_top[COEF_W*q +: COEF_W]);
      coefs[3 + q] = coef_t'(coef_row_mid[COEF_W*q +: COEF_W]);
      coefs[6 + q] = coef_t'(coef_row_bot[COEF_W*q +: COEF_W]);
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      for (int t = 0; t < TAPS; t++) begin
        lane_taps[l][t] = window_regs[t][CHAN_W*l +: CHAN_W];
      end
    end
  end

  assign lane_ctl.prod_en = ready3;
  assign lane_ctl.sum_en  = ready4;

  // One lane per color channel.
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    c3f_lane u_lane (
      .clk   (clk),
      .ctl   (lane_ctl),
      .taps  (lane_taps[l]),
      .coefs (coefs),
      .sum   (lane_sum[l])
    );
  end

  c3f_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .sum_valid  (s4_v),
    .sum_last   (s4_last),
    .color_mode (color_mode),
    .sums       (lane_sum),
    .out_stall  (out_stall),
    .load_ready (ready_out),
    .out_valid  (out_valid),
    .out_zero   (out_zero),
    .out_one    (out_one),
    .out_two    (out_two),
    .frame_last (frame_last)
  );

endmodule

@@ hw/rtl/c3f_ram.sv @@
`timescale 1ns / 1ps

module c3f_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle; a read at the written
  // address returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/c3f_lane.sv @@
`timescale 1ns / 1ps

module c3f_lane (
  input  logic               clk,
  input  c3f_pkg::lane_ctl_t ctl,
  input  c3f_pkg::chan_t     taps  [9],
  input  c3f_pkg::coef_t     coefs [9],
  output c3f_pkg::sum_t      sum
);
  import c3f_pkg::*;

  logic signed [PROD_W-1:0] prod [TAPS];
  sum_t                     sum_next;

  // Nine products of one channel, registered.
  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      for (int t = 0; t < TAPS; t++) begin
        prod[t] <= $signed({1'b0, taps[t]}) * coefs[t];
      end
    end
  end

  // Sum of the registered products.
  always_comb begin
    sum_next = '0;
    for (int t = 0; t < TAPS; t++) begin
      sum_next = sum_next + SUM_W'(prod[t]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      sum <= sum_next;
    end
  end

endmodule

@@ hw/rtl/c3f_merge.sv @@
`timescale 1ns / 1ps

module c3f_merge (
  input  logic           clk,
  input  logic           rst,
  input  logic           sum_valid,
  input  logic           sum_last,
  input  logic           color_mode,
  input  c3f_pkg::sum_t  sums [3],
  input  logic           out_stall,
  output logic           load_ready,
  output logic           out_valid,
  output c3f_pkg::chan_t out_zero,
  output c3f_pkg::chan_t out_one,
  output c3f_pkg::chan_t out_two,
  output logic           frame_last
);
  import c3f_pkg::*;

  // Drop the fraction, map negative sums to zero and saturate at full scale.
  function automatic chan_t clamp_sum(input sum_t s);
    chan_t r;
    if (s[SUM_W-1]) begin
      r = '0;
    end else if (|s[SUM_W-2:FRAC_W+CHAN_W]) begin
      r = '1;
    end else begin
      r = s[FRAC_W+CHAN_W-1:FRAC_W];
    end
    return r;
  endfunction

  // The output register takes a new result when it is empty or its
  // current one is transferred.
  assign load_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ready) begin
      out_valid <= sum_valid;
    end
  end

  // Merge the lanes; in grey mode only channel zero carries a result.
  always_ff @(posedge clk) begin
    if (load_ready) begin
      out_zero   <= clamp_sum(sums[0]);
      out_one    <= (color_mode == GREY) ? '0 : clamp_sum(sums[1]);
      out_two    <= (color_mode == GREY) ? '0 : clamp_sum(sums[2]);
      frame_last <= sum_last;
    end
  end

endmodule

@@ hw/rtl/c3f_checker.sv @@
`timescale 1ns / 1ps

module c3f_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_zero,
  input logic [7:0] out_one,
  input logic [7:0] out_two,
  input logic       frame_last
);

  // A stalled result stays in place until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_zero) && $stable(out_one)
      && $stable(out_two) && $stable(frame_last))
    else $error("stalled result changed");

  // With the output register empty the pipeline can always move.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // A result never appears in the cycle right after reset.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !out_valid)
    else $error("result without an accepted pixel");

endmodule

bind conv3x3_image_filter_unit c3f_checker u_c3f_checker (.*);

@@ tb/tb_conv3x3_image_filter_unit.sv @@
`timescale 1ns / 1ps

module tb_conv3x3_image_filter_unit;
  import c3f_pkg::*;

  localparam int LINE_DEPTH    = MAX_PADDED_WIDTH_DEF;
  localparam int MAX_IWIDTH    = LINE_DEPTH - 2;
  localparam int PRIME_IWIDTH  = 100;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PIXELS = 1100;
  localparam int HOLD_AFTER    = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_LIMIT   = 50000;

  typedef struct packed {
    chan_t c0;
    chan_t c1;
    chan_t c2;
    logic  fs;
  } pixel_t;

  typedef struct packed {
    chan_t o0;
    chan_t o1;
    chan_t o2;
    logic  last;
  } result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  chan_t                 chan_zero = '0;
  chan_t                 chan_one = '0;
  chan_t                 chan_two = '0;
  logic                  frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  chan_t                 out_zero;
  chan_t                 out_one;
  chan_t                 out_two;
  logic                  frame_last;

  // Predictor copy of the configuration registers.
  logic [CFG_DATA_W-1:0] kern_top;
  logic [CFG_DATA_W-1:0] kern_mid;
  logic [CFG_DATA_W-1:0] kern_bot;
  logic [IWIDTH_W-1:0]   cfg_iw;
  logic [IHEIGHT_W-1:0]  cfg_ih;
  logic                  cfg_color;

  // Predictor copy of the line stores, the window and the frame position.
  logic [PIX_W-1:0] upper_line [LINE_DEPTH];
  logic [PIX_W-1:0] middle_line [LINE_DEPTH];
  logic [PIX_W-1:0] win [TAPS];
  int               col_pos;
  int               row_pos;

  pixel_t  pixel_queue [$];
  result_t filtered_queue [$];
  pixel_t  cur_pixel;
  result_t got;
  result_t want;

  logic idling_on = 1'b0;
  int   feed_gap = 0;
  int   stall_left = 0;
  logic hold_done = 1'b0;
  int   pixels_fed = 0;
  int   random_fed = 0;
  int   results_seen = 0;
  int   frame_ends = 0;
  int   phases = 0;
  int   mismatches = 0;

  conv3x3_image_filter_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .chan_zero   (chan_zero),
    .chan_one    (chan_one),
    .chan_two    (chan_two),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_zero    (out_zero),
    .out_one     (out_one),
    .out_two     (out_two),
    .frame_last  (frame_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Safety net against a hung handshake.
  initial begin
    #18_000_000;
    $display("tb_conv3x3_image_filter_unit: FAIL");
    $finish;
  end

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    else if (r < 94) return $urandom_range(1, 3);
    else return $urandom_range(10, 30);
  endfunction

  function automatic chan_t pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    else if (r < 20) return 8'hFF;
    else return chan_t'($urandom);
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return COEF_W'($urandom);
    else if (r < 60) return COEF_W'($urandom_range(0, 1024) - 512);
    else if (r < 70) return 16'h7FFF;
    else if (r < 80) return 16'h8000;
    else if (r < 88) return 16'h0000;
    else return 16'h0100;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_coef_row();
    return {pick_coef(), pick_coef(), pick_coef()};
  endfunction

  // Register values outside the supported geometry are clamped.
  function automatic int eff_width(input int v);
    if (v < 1) return 1;
    if (v > MAX_IWIDTH) return MAX_IWIDTH;
    return v;
  endfunction

  function automatic int eff_height(input int v);
    if (v < 1) return 1;
    if (v > int'(MAX_INTERIOR_HEIGHT)) return int'(MAX_INTERIOR_HEIGHT);
    return v;
  endfunction

  // One channel of the window through the Q8.8 kernel, truncated and clamped.
  function automatic chan_t kernel_sum(input int sh);
    int acc;
    int p;
    int q;
    int pxv;
    int kv;
    logic [CFG_DATA_W-1:0] krow;
    acc = 0;
    for (p = 0; p < 3; p++) begin
      krow = (p == 0) ? kern_top : (p == 1) ? kern_mid : kern_bot;
      for (q = 0; q < 3; q++) begin
        pxv = win[p * 3 + q][sh +: CHAN_W];
        kv = coef_t'(krow[COEF_W * q +: COEF_W]);
        acc += pxv * kv;
      end
    end
    if (acc < 0) return 8'd0;
    if ((acc >>> FRAC_W) > 255) return 8'd255;
    return chan_t'(acc >>> FRAC_W);
  endfunction

  // Advance the frame position by one pixel and queue its filtered result.
  task automatic filter_pixel(input pixel_t px);
    int w;
    int h;
    int c;
    int r;
    logic [PIX_W-1:0] up_v;
    logic [PIX_W-1:0] mid_v;
    result_t res;
    w = eff_width(int'(cfg_iw)) + 2;
    h = eff_height(int'(cfg_ih)) + 2;
    if (px.fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    up_v = upper_line[c];
    mid_v = middle_line[c];
    win[0] = win[1]; win[1] = win[2]; win[2] = up_v;
    win[3] = win[4]; win[4] = win[5]; win[5] = mid_v;
    win[6] = win[7]; win[7] = win[8]; win[8] = {px.c2, px.c1, px.c0};
    upper_line[c] = mid_v;
    middle_line[c] = {px.c2, px.c1, px.c0};
    if (r >= 2 && c >= 2) begin
      res.o0 = kernel_sum(0);
      if (cfg_color == GREY) begin
        res.o1 = '0;
        res.o2 = '0;
      end else begin
        res.o1 = kernel_sum(CHAN_W);
        res.o2 = kernel_sum(2 * CHAN_W);
      end
      res.last = (r == h - 1) && (c == w - 1);
      filtered_queue.push_back(res);
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic queue_pixel(input chan_t a, input chan_t b, input chan_t c, input logic fs);
    pixel_queue.push_back(pixel_t'({a, b, c, fs}));
  endtask

  // Register write; the predictor takes the value at the transfer edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_COEF_TOP:   kern_top = val;
      REG_COEF_MID:   kern_mid = val;
      REG_COEF_BOT:   kern_bot = val;
      REG_INT_WIDTH:  cfg_iw = val[IWIDTH_W-1:0];
      REG_INT_HEIGHT: cfg_ih = val[IHEIGHT_W-1:0];
      REG_COLOR_MODE: cfg_color = val[0];
      default: ;
    endcase
  endtask

  // Padding pixels leave no result behind, so let the pipeline settle too.
  task automatic wait_idle();
    do @(posedge clk);
    while (pixel_queue.size() > 0 || in_valid || filtered_queue.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One setting of the block followed by a mix of frames, cut frames and noise.
  // Interior widths stay within the columns written by the first frame.
  task automatic run_random_phase();
    int r;
    int iw_reg;
    int ih_reg;
    int frame_len;
    int budget;
    int queued;
    int kind;
    int n;
    int k;
    logic fs_bit;
    r = $urandom_range(0, 99);
    if (r < 70) iw_reg = $urandom_range(1, 6);
    else if (r < 85) iw_reg = $urandom_range(7, 24);
    else if (r < 93) iw_reg = $urandom_range(25, PRIME_IWIDTH);
    else iw_reg = 0;
    r = $urandom_range(0, 99);
    if (r < 75) ih_reg = $urandom_range(1, 4);
    else if (r < 85) ih_reg = $urandom_range(5, 8);
    else if (r < 92) ih_reg = 0;
    else ih_reg = $urandom_range(65533, 65535);
    write_reg(REG_COEF_TOP, pick_coef_row());
    write_reg(REG_COEF_MID, pick_coef_row());
    write_reg(REG_COEF_BOT, pick_coef_row());
    write_reg(REG_INT_WIDTH, CFG_DATA_W'(iw_reg));
    write_reg(REG_INT_HEIGHT, CFG_DATA_W'(ih_reg));
    write_reg(REG_COLOR_MODE, CFG_DATA_W'($urandom_range(0, 1)));
    idling_on = ($urandom_range(0, 3) != 0);
    frame_len = (eff_width(iw_reg) + 2) * (eff_height(ih_reg) + 2);
    if (frame_len > 300) frame_len = 300;
    budget = $urandom_range(40, 160);
    queued = 0;
    while (queued < budget) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) n = frame_len;
      else if (kind < 88) n = $urandom_range(1, frame_len);
      else n = $urandom_range(1, 10);
      for (k = 0; k < n; k++) begin
        if (kind < 88) fs_bit = (k == 0) && ($urandom_range(0, 6) != 0);
        else fs_bit = ($urandom_range(0, 9) == 0);
        queue_pixel(pick_byte(), pick_byte(), pick_byte(), fs_bit);
      end
      queued += n;
    end
    random_fed += queued;
    phases++;
    wait_idle();
  endtask

  // Pixel driver: a new pixel is presented only after the previous transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      feed_gap = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        filter_pixel(cur_pixel);
        pixels_fed++;
      end
      if (feed_gap > 0) begin
        feed_gap--;
        in_valid <= 1'b0;
      end else if (pixel_queue.size() > 0) begin
        cur_pixel = pixel_queue.pop_front();
        chan_zero <= cur_pixel.c0;
        chan_one <= cur_pixel.c1;
        chan_two <= cur_pixel.c2;
        frame_start <= cur_pixel.fs;
        in_valid <= 1'b1;
        feed_gap = idling_on ? idle_span() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall: random gaps, plus one long hold-off while pixels keep coming.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = idling_on ? idle_span() : 0;
      end
    end
  end

  // Result monitor: each transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got = {out_zero, out_one, out_two, frame_last};
      results_seen++;
      if (frame_last === 1'b1) frame_ends++;
      if (filtered_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none pending: %0d/%0d/%0d last %b",
                   $realtime, got.o0, got.o1, got.o2, got.last);
      end else begin
        want = filtered_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: expected %0d/%0d/%0d last %b, got %0d/%0d/%0d last %b",
                     $realtime, want.o0, want.o1, want.o2, want.last,
                     got.o0, got.o1, got.o2, got.last);
        end
      end
    end
  end

  initial begin
    int k;
    int spin;
    for (k = 0; k < LINE_DEPTH; k++) begin
      upper_line[k] = '0;
      middle_line[k] = '0;
    end
    for (k = 0; k < TAPS; k++) win[k] = '0;
    col_pos = 0;
    row_pos = 0;
    kern_top = '0;
    kern_mid = CFG_DATA_W'(256);
    kern_bot = '0;
    cfg_iw = IWIDTH_W'(1022);
    cfg_ih = IHEIGHT_W'(1);
    cfg_color = GREY;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset kernel over the widest row used later: one full frame, no idling,
    // with the long result hold-off landing inside it. It also fills every
    // line store column that later settings can reach.
    write_reg(REG_INT_WIDTH, CFG_DATA_W'(PRIME_IWIDTH));
    for (k = 0; k < 3 * (PRIME_IWIDTH + 2); k++)
      queue_pixel(pick_byte(), pick_byte(), pick_byte(), k == 0);
    wait_idle();

    // Directed 1x1 RGB frame: channel zero saturates high, channel one goes
    // negative, channel two truncates a fractional sum.
    idling_on = 1'b1;
    write_reg(REG_COEF_TOP, 48'h0000_8000_7FFF);
    write_reg(REG_COEF_MID, 48'h0100_0100_0100);
    write_reg(REG_COEF_BOT, 48'hFFFF_0000_0000);
    write_reg(REG_INT_WIDTH, CFG_DATA_W'(1));
    write_reg(REG_INT_HEIGHT, CFG_DATA_W'(1));
    write_reg(REG_COLOR_MODE, CFG_DATA_W'(1));
    for (k = 0; k < 9; k++)
      queue_pixel((k == 1) ? 8'd0 : 8'd255, (k == 0) ? 8'd0 : 8'd255,
                  (k < 3) ? 8'd0 : 8'd40, k == 0);
    wait_idle();

    // Same pixels in grey mode with zero geometry (clamped up to one) and no
    // frame start, so the position has to wrap on its own.
    write_reg(REG_INT_WIDTH, CFG_DATA_W'(0));
    write_reg(REG_INT_HEIGHT, CFG_DATA_W'(0));
    write_reg(REG_COLOR_MODE, CFG_DATA_W'(GREY));
    for (k = 0; k < 9; k++)
      queue_pixel((k == 1) ? 8'd0 : 8'd255, (k == 0) ? 8'd0 : 8'd255,
                  (k < 3) ? 8'd0 : 8'd40, 1'b0);
    wait_idle();

    while (random_fed < RANDOM_PIXELS) run_random_phase();

    // Final drain, bounded so leftover predictions are reported.
    spin = 0;
    while ((pixel_queue.size() > 0 || in_valid || filtered_queue.size() > 0)
           && spin < DRAIN_LIMIT) begin
      @(posedge clk);
      spin++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (filtered_queue.size() > 0) begin
      mismatches++;
      $display("%0d predicted results never arrived", filtered_queue.size());
    end

    $display("Fed %0d pixels over %0d random settings plus directed frames.",
             pixels_fed, phases);
    $display("Checked %0d filtered results, %0d frame ends, %0d mismatches.",
             results_seen, frame_ends, mismatches);
    if (mismatches == 0)
      $display("tb_conv3x3_image_filter_unit: PASS");
    else
      $display("tb_conv3x3_image_filter_unit: FAIL");
    $finish;
  end

endmodule

@@ conv3x3_image_filter_unit.f @@
hw/rtl/c3f_pkg.sv
hw/rtl/c3f_ram.sv
hw/rtl/c3f_lane.sv
hw/rtl/c3f_merge.sv
hw/rtl/conv3x3_image_filter_unit.sv
hw/rtl/c3f_checker.sv
tb/tb_conv3x3_image_filter_unit.sv
